FILE: rtl/tls_sni_extractor_assert.svh
// Assertion macros used by the checker file of the server name extractor.
// Needs a clk and an arst_n in the scope where the macros are used.
`ifndef TLS_SNI_EXTRACTOR_ASSERT_SVH
`define TLS_SNI_EXTRACTOR_ASSERT_SVH

// Same-cycle implication, inactive during reset.
`define TSE_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, inactive during reset.
`define TSE_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: rtl/tse_pkg.sv
// Package of the TLS server name extractor: parser phases, header codes,
// result beat type and queue sizing. No dependencies.
`default_nettype none

package tse_pkg;

	localparam int POSITION_BITS_DEF = 17;

	// Header codes
	localparam logic [7:0]  REC_HANDSHAKE   = 8'h16;
	localparam logic [7:0]  HS_CLIENT_HELLO = 8'h01;
	localparam logic [15:0] EXT_SERVER_NAME = 16'h0000;
	localparam logic [7:0]  NAME_TYPE_HOST  = 8'h00;

	// Byte counts of fixed-length parts
	localparam int REC_HDR_REST  = 4;       // version and record length
	localparam int HS_FIXED_LEN  = 3 + 34;  // handshake length, version, random
	localparam int EXT_HDR_LEN   = 4;
	localparam int SNI_MIN_LEN   = 5;

	// Result kinds
	localparam logic KIND_NAME    = 1'b0;
	localparam logic KIND_VERDICT = 1'b1;

	// Result queue
	localparam int Q_DEPTH = 4;
	localparam int Q_AW    = $clog2(Q_DEPTH);

	typedef enum logic [3:0] {
		PH_RECORD   = 4'd0,
		PH_REC_SKIP = 4'd1,
		PH_HS_TYPE  = 4'd2,
		PH_FIX_SKIP = 4'd3,
		PH_SID_LEN  = 4'd4,
		PH_SID_SKIP = 4'd5,
		PH_CS_LEN   = 4'd6,
		PH_CS_SKIP  = 4'd7,
		PH_CM_LEN   = 4'd8,
		PH_CM_SKIP  = 4'd9,
		PH_EXTS_LEN = 4'd10,
		PH_EXT_HDR  = 4'd11,
		PH_EXT_BODY = 4'd12,
		PH_SNI_HDR  = 4'd13,
		PH_NAME     = 4'd14,
		PH_DONE     = 4'd15
	} phase_t;

	typedef struct packed {
		logic        kind;
		logic [7:0]  name_char;
		logic        found;
		logic [15:0] name_length;
		logic        run_end;
	} res_t;

endpackage

`default_nettype wire

FILE: rtl/tls_sni_extractor.sv
// TLS Client Hello server name extractor: byte parser and result queue; needs tse_pkg.
// Results: each beat is written to the queue on the accepting edge and offered in order behind earlier beats.
// Throughput: one payload byte per cycle; the parser state advances on the
// accepting edge. A final byte that is also a name byte yields two beats
// through a four-entry result queue; in_ready drops while fewer than two slots are free.
// Reset: arst_n clears parser state and queue; each final byte restarts the parser.
`default_nettype none

module tls_sni_extractor #(
	parameter int POSITION_BITS = tse_pkg::POSITION_BITS_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [7:0]  data_byte,
	input  wire logic        final_byte,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic             kind,
	output logic [7:0]       name_char,
	output logic             found,
	output logic [15:0]      name_length,
	output logic             run_end
);

	localparam int P = POSITION_BITS;
	localparam logic [P-1:0] POS_MAX = {P{1'b1}};

	tse_pkg::phase_t ph_q, ph_n;
	logic [P-1:0]  pos_q, pos_n, skip_q, skip_n;
	logic [P-1:0]  exts_lim_q, exts_lim_n, ext_lim_q, ext_lim_n;
	logic [15:0]   acc_q, acc_n, ext_kind_q, ext_kind_n;
	logic [15:0]   name_rem_q, name_rem_n, held_q, held_n;
	logic          match_q, match_n, fin_q, fin_n;

	logic          accept;
	logic [P-1:0]  pos_inc, skip_inc, skip_dec, rest, lim_sat;
	logic [15:0]   acc_shift;
	logic [P:0]    lim, hdr_end;
	logic          past_exts_cur, past_exts_new;
	logic          name_hit;

	tse_pkg::res_t fifo_q [tse_pkg::Q_DEPTH];
	logic [tse_pkg::Q_AW-1:0] wr_ptr_q, rd_ptr_q;
	logic [tse_pkg::Q_AW:0]   count_q;
	tse_pkg::res_t e0, e1;
	logic [1:0]    n_push;
	logic          pop, found_v;

	assign accept    = in_valid & in_ready;
	assign pos_inc   = pos_q + 1'b1;
	assign skip_inc  = skip_q + 1'b1;
	assign skip_dec  = skip_q - 1'b1;
	assign acc_shift = {acc_q[7:0], data_byte};
	assign lim       = {1'b0, pos_inc} + (P+1)'(acc_shift);
	assign lim_sat   = (lim > {1'b0, POS_MAX}) ? POS_MAX : lim[P-1:0];
	assign hdr_end   = {1'b0, pos_inc} + (P+1)'(tse_pkg::EXT_HDR_LEN);
	assign past_exts_cur = hdr_end > {1'b0, exts_lim_q};
	assign past_exts_new = hdr_end > {1'b0, lim_sat};
	assign rest      = ext_lim_q - pos_inc;

	// Parser next state
	always_comb begin
		ph_n       = ph_q;
		pos_n      = pos_q;
		skip_n     = skip_q;
		acc_n      = acc_q;
		exts_lim_n = exts_lim_q;
		ext_kind_n = ext_kind_q;
		ext_lim_n  = ext_lim_q;
		name_rem_n = name_rem_q;
		held_n     = held_q;
		match_n    = match_q;
		fin_n      = fin_q;
		name_hit   = 1'b0;
		if (pos_q != POS_MAX) begin
			pos_n = pos_inc;
			case (ph_q)
				tse_pkg::PH_RECORD: begin
					acc_n = '0;
					if (data_byte == tse_pkg::REC_HANDSHAKE) begin
						ph_n   = tse_pkg::PH_REC_SKIP;
						skip_n = P'(tse_pkg::REC_HDR_REST);
					end else begin
						ph_n   = tse_pkg::PH_DONE;
						skip_n = '0;
					end
				end
				tse_pkg::PH_REC_SKIP: begin
					skip_n = skip_dec;
					if (skip_dec == '0) begin
						ph_n  = tse_pkg::PH_HS_TYPE;
						acc_n = '0;
					end
				end
				tse_pkg::PH_HS_TYPE: begin
					acc_n = '0;
					if (data_byte == tse_pkg::HS_CLIENT_HELLO) begin
						ph_n   = tse_pkg::PH_FIX_SKIP;
						skip_n = P'(tse_pkg::HS_FIXED_LEN);
					end else begin
						ph_n   = tse_pkg::PH_DONE;
						skip_n = '0;
					end
				end
				tse_pkg::PH_FIX_SKIP: begin
					skip_n = skip_dec;
					if (skip_dec == '0) begin
						ph_n  = tse_pkg::PH_SID_LEN;
						acc_n = '0;
					end
				end
				tse_pkg::PH_SID_LEN: begin
					acc_n  = '0;
					skip_n = P'(data_byte);
					ph_n   = (data_byte == 8'd0) ? tse_pkg::PH_CS_LEN : tse_pkg::PH_SID_SKIP;
				end
				tse_pkg::PH_SID_SKIP: begin
					skip_n = skip_dec;
					if (skip_dec == '0) begin
						ph_n  = tse_pkg::PH_CS_LEN;
						acc_n = '0;
					end
				end
				tse_pkg::PH_CS_LEN: begin
					acc_n  = acc_shift;
					skip_n = skip_inc;
					if (skip_inc == P'(2)) begin
						acc_n  = '0;
						skip_n = P'(acc_shift);
						ph_n   = (acc_shift == 16'd0) ? tse_pkg::PH_CM_LEN
							: tse_pkg::PH_CS_SKIP;
					end
				end
				tse_pkg::PH_CS_SKIP: begin
					skip_n = skip_dec;
					if (skip_dec == '0) begin
						ph_n  = tse_pkg::PH_CM_LEN;
						acc_n = '0;
					end
				end
				tse_pkg::PH_CM_LEN: begin
					acc_n  = '0;
					skip_n = P'(data_byte);
					ph_n   = (data_byte == 8'd0) ? tse_pkg::PH_EXTS_LEN
						: tse_pkg::PH_CM_SKIP;
				end
				tse_pkg::PH_CM_SKIP: begin
					skip_n = skip_dec;
					if (skip_dec == '0) begin
						ph_n  = tse_pkg::PH_EXTS_LEN;
						acc_n = '0;
					end
				end
				tse_pkg::PH_EXTS_LEN: begin
					acc_n  = acc_shift;
					skip_n = skip_inc;
					if (skip_inc == P'(2)) begin
						exts_lim_n = lim_sat;
						acc_n      = '0;
						skip_n     = '0;
						ph_n       = past_exts_new ? tse_pkg::PH_DONE : tse_pkg::PH_EXT_HDR;
					end
				end
				tse_pkg::PH_EXT_HDR: begin
					acc_n  = acc_shift;
					skip_n = skip_inc;
					if (skip_inc == P'(2)) begin
						ext_kind_n = acc_shift;
						acc_n      = '0;
					end else if (skip_inc == P'(4)) begin
						acc_n  = '0;
						skip_n = '0;
						if (lim > {1'b0, exts_lim_q}) begin
							ph_n = tse_pkg::PH_DONE;
						end else begin
							ext_lim_n = lim[P-1:0];
							if (ext_kind_q == tse_pkg::EXT_SERVER_NAME
									&& acc_shift >= 16'(tse_pkg::SNI_MIN_LEN)) begin
								ph_n = tse_pkg::PH_SNI_HDR;
							end else if (acc_shift == 16'd0) begin
								ph_n = past_exts_cur ? tse_pkg::PH_DONE
									: tse_pkg::PH_EXT_HDR;
							end else begin
								ph_n   = tse_pkg::PH_EXT_BODY;
								skip_n = P'(acc_shift);
							end
						end
					end
				end
				tse_pkg::PH_EXT_BODY: begin
					skip_n = skip_dec;
					if (skip_dec == '0) begin
						acc_n = '0;
						ph_n  = past_exts_cur ? tse_pkg::PH_DONE : tse_pkg::PH_EXT_HDR;
					end
				end
				tse_pkg::PH_SNI_HDR: begin
					skip_n = skip_inc;
					if (skip_inc == P'(3)) begin
						ext_kind_n = 16'(data_byte);
					end else if (skip_inc >= P'(4)) begin
						acc_n = acc_shift;
						if (skip_inc == P'(5)) begin
							acc_n  = '0;
							skip_n = '0;
							if (ext_kind_q == 16'(tse_pkg::NAME_TYPE_HOST)
									&& P'(acc_shift) <= rest) begin
								match_n = 1'b1;
								held_n  = acc_shift;
								if (acc_shift == 16'd0) begin
									fin_n = 1'b1;
									ph_n  = tse_pkg::PH_DONE;
								end else begin
									ph_n       = tse_pkg::PH_NAME;
									name_rem_n = acc_shift;
								end
							end else if (rest == '0) begin
								ph_n = past_exts_cur ? tse_pkg::PH_DONE
									: tse_pkg::PH_EXT_HDR;
							end else begin
								ph_n   = tse_pkg::PH_EXT_BODY;
								skip_n = rest;
							end
						end
					end
				end
				tse_pkg::PH_NAME: begin
					name_hit   = 1'b1;
					name_rem_n = name_rem_q - 1'b1;
					if (name_rem_q == 16'd1) begin
						fin_n  = 1'b1;
						ph_n   = tse_pkg::PH_DONE;
						skip_n = '0;
						acc_n  = '0;
					end
				end
				default: begin
					ph_n   = tse_pkg::PH_DONE;
					skip_n = '0;
					acc_n  = '0;
				end
			endcase
		end
	end

	// Result beats for this byte
	always_comb begin
		found_v = fin_n & match_n & (ext_lim_n <= pos_n);
		e0 = '0;
		e1 = '0;
		e1.kind        = tse_pkg::KIND_VERDICT;
		e1.found       = found_v;
		e1.name_length = found_v ? held_n : 16'd0;
		e1.run_end     = 1'b1;
		n_push = 2'd0;
		if (name_hit) begin
			e0.kind      = tse_pkg::KIND_NAME;
			e0.name_char = data_byte;
			e0.run_end   = ~final_byte;
			n_push       = final_byte ? 2'd2 : 2'd1;
		end else if (final_byte) begin
			e0     = e1;
			n_push = 2'd1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ph_q       <= tse_pkg::PH_RECORD;
			pos_q      <= '0;
			skip_q     <= '0;
			acc_q      <= '0;
			exts_lim_q <= '0;
			ext_kind_q <= '0;
			ext_lim_q  <= '0;
			name_rem_q <= '0;
			held_q     <= '0;
			match_q    <= 1'b0;
			fin_q      <= 1'b0;
		end else if (accept) begin
			if (final_byte) begin
				// restart for the next packet
				ph_q       <= tse_pkg::PH_RECORD;
				pos_q      <= '0;
				skip_q     <= '0;
				acc_q      <= '0;
				exts_lim_q <= '0;
				ext_kind_q <= '0;
				ext_lim_q  <= '0;
				name_rem_q <= '0;
				held_q     <= '0;
				match_q    <= 1'b0;
				fin_q      <= 1'b0;
			end else begin
				ph_q       <= ph_n;
				pos_q      <= pos_n;
				skip_q     <= skip_n;
				acc_q      <= acc_n;
				exts_lim_q <= exts_lim_n;
				ext_kind_q <= ext_kind_n;
				ext_lim_q  <= ext_lim_n;
				name_rem_q <= name_rem_n;
				held_q     <= held_n;
				match_q    <= match_n;
				fin_q      <= fin_n;
			end
		end
	end

	// Result queue
	assign pop       = out_valid & out_ready;
	assign out_valid = count_q != '0;
	assign in_ready  = count_q <= (tse_pkg::Q_AW+1)'(tse_pkg::Q_DEPTH - 2);

	always_ff @(posedge clk) begin
		if (accept && n_push != 2'd0) begin
			fifo_q[wr_ptr_q] <= e0;
		end
		if (accept && n_push == 2'd2) begin
			fifo_q[wr_ptr_q + 1'b1] <= e1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (accept) begin
				wr_ptr_q <= wr_ptr_q + (tse_pkg::Q_AW)'(n_push);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			count_q <= count_q + (tse_pkg::Q_AW+1)'(accept ? n_push : 2'd0)
				- (tse_pkg::Q_AW+1)'(pop);
		end
	end

	assign kind        = fifo_q[rd_ptr_q].kind;
	assign name_char   = fifo_q[rd_ptr_q].name_char;
	assign found       = fifo_q[rd_ptr_q].found;
	assign name_length = fifo_q[rd_ptr_q].name_length;
	assign run_end     = fifo_q[rd_ptr_q].run_end;

endmodule

`default_nettype wire

FILE: rtl/tse_checker.sv
// Port-level checker for the server name extractor, bound to the top level.
// Depends on tse_pkg and tls_sni_extractor_assert.svh.
`default_nettype none

`include "tls_sni_extractor_assert.svh"

module tse_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        in_valid,
	input wire logic        in_ready,
	input wire logic [7:0]  data_byte,
	input wire logic        final_byte,
	input wire logic        out_valid,
	input wire logic        out_ready,
	input wire logic        kind,
	input wire logic [7:0]  name_char,
	input wire logic        found,
	input wire logic [15:0] name_length,
	input wire logic        run_end
);

	// A stalled result beat holds
	`TSE_ASSERT_NEXT(a_out_hold, out_valid && !out_ready,
		out_valid && $stable(kind) && $stable(name_char) && $stable(found)
		&& $stable(name_length) && $stable(run_end), "result beat changed while stalled")

	// A name beat that does not end its run is followed at once by the verdict
	`TSE_ASSERT_NEXT(a_verdict_follows,
		out_valid && out_ready && kind == tse_pkg::KIND_NAME && !run_end,
		out_valid && kind == tse_pkg::KIND_VERDICT, "verdict missing after final name beat")

	// Every verdict closes its run
	`TSE_ASSERT_NOW(a_verdict_end, out_valid && kind == tse_pkg::KIND_VERDICT,
		run_end, "verdict without run end")

	// A miss reports no length
	`TSE_ASSERT_NOW(a_miss_len, out_valid && kind == tse_pkg::KIND_VERDICT && !found,
		name_length == 16'd0, "length reported for a miss")

endmodule

bind tls_sni_extractor tse_checker u_tse_checker (.*);

`default_nettype wire

FILE: dv/tb_tls_sni_extractor.sv
`timescale 1ns / 100ps
// Self-checking bench for tls_sni_extractor: Client Hello packets, broken and noise
// packets, checked beat by beat.
// Needs tse_pkg and the extractor RTL.

module tb_tls_sni_extractor;
	import tse_pkg::*;

	localparam int POS_MAX = (1 << POSITION_BITS_DEF) - 1;
	localparam int QUIET_FROM = 1200;
	localparam int QUIET_TO = 2000;
	localparam int DRAIN_CYCLES = 20;
	localparam longint TIMEOUT_NS = 64'd15_000_000;

	typedef logic [7:0] octets_t [$];
	typedef struct {
		logic [7:0] data;
		logic       last;
		bit         drain;
	} stim_t;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_ready;
	logic [7:0]  data_byte;
	logic        final_byte;
	logic        out_valid;
	logic        out_ready;
	logic        kind;
	logic [7:0]  name_char;
	logic        found;
	logic [15:0] name_length;
	logic        run_end;

	stim_t stim_q [$];
	res_t sni_beats_due [$];
	bit in_taken;
	int unsigned cycle_count;
	int mismatch_count;

	// parser copy
	phase_t      hs_phase;
	logic [16:0] hs_pos;
	logic [16:0] hs_count;
	logic [15:0] hs_acc;
	logic [16:0] hs_exts_end;
	logic [15:0] hs_ext_type;
	logic [16:0] hs_ext_end;
	logic [15:0] hs_name_left;
	logic [15:0] hs_name_len;
	bit          hs_matched;
	bit          hs_complete;

	tls_sni_extractor uut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.data_byte(data_byte),
		.final_byte(final_byte),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.kind(kind),
		.name_char(name_char),
		.found(found),
		.name_length(name_length),
		.run_end(run_end)
	);

	task automatic clear_parser();
		hs_phase = PH_RECORD;
		hs_pos = '0;
		hs_count = '0;
		hs_acc = '0;
		hs_exts_end = '0;
		hs_ext_type = '0;
		hs_ext_end = '0;
		hs_name_left = '0;
		hs_name_len = '0;
		hs_matched = 0;
		hs_complete = 0;
	endtask

	task automatic enter_phase(input phase_t ph);
		hs_phase = ph;
		hs_count = '0;
		hs_acc = '0;
	endtask

	task automatic skip_or_enter(input int n, input phase_t skip_ph, input phase_t next_ph);
		if (n == 0) begin
			enter_phase(next_ph);
		end else begin
			enter_phase(skip_ph);
			hs_count = 17'(n);
		end
	endtask

	task automatic open_ext_header();
		if (int'(hs_pos) + EXT_HDR_LEN > int'(hs_exts_end))
			enter_phase(PH_DONE);
		else
			enter_phase(PH_EXT_HDR);
	endtask

	task automatic parse_octet(input logic [7:0] b, output bit is_name);
		int v;
		int lim;
		int rest;
		is_name = 0;
		case (hs_phase)
			PH_RECORD: begin
				if (b == REC_HANDSHAKE) begin
					enter_phase(PH_REC_SKIP);
					hs_count = 17'(REC_HDR_REST);
				end else begin
					enter_phase(PH_DONE);
				end
			end
			PH_HS_TYPE: begin
				if (b == HS_CLIENT_HELLO) begin
					enter_phase(PH_FIX_SKIP);
					hs_count = 17'(HS_FIXED_LEN);
				end else begin
					enter_phase(PH_DONE);
				end
			end
			// each skip hands over to the phase numbered right after it
			PH_REC_SKIP, PH_FIX_SKIP, PH_SID_SKIP, PH_CS_SKIP, PH_CM_SKIP: begin
				hs_count = hs_count - 1'b1;
				if (hs_count == 0)
					enter_phase(phase_t'(hs_phase + 1'b1));
			end
			PH_SID_LEN: skip_or_enter(int'(b), PH_SID_SKIP, PH_CS_LEN);
			PH_CM_LEN: skip_or_enter(int'(b), PH_CM_SKIP, PH_EXTS_LEN);
			PH_CS_LEN: begin
				hs_acc = {hs_acc[7:0], b};
				v = hs_acc;
				hs_count = hs_count + 1'b1;
				if (hs_count == 2)
					skip_or_enter(v, PH_CS_SKIP, PH_CM_LEN);
			end
			PH_EXTS_LEN: begin
				hs_acc = {hs_acc[7:0], b};
				v = hs_acc;
				hs_count = hs_count + 1'b1;
				if (hs_count == 2) begin
					lim = int'(hs_pos) + v;
					hs_exts_end = 17'(lim > POS_MAX ? POS_MAX : lim);
					open_ext_header();
				end
			end
			PH_EXT_HDR: begin
				hs_acc = {hs_acc[7:0], b};
				v = hs_acc;
				hs_count = hs_count + 1'b1;
				if (hs_count == 2) begin
					hs_ext_type = 16'(v);
					hs_acc = '0;
				end else if (hs_count == 4) begin
					lim = int'(hs_pos) + v;
					if (lim > POS_MAX || lim > int'(hs_exts_end)) begin
						enter_phase(PH_DONE);
					end else begin
						hs_ext_end = 17'(lim);
						if (hs_ext_type == EXT_SERVER_NAME && v >= SNI_MIN_LEN) begin
							enter_phase(PH_SNI_HDR);
						end else if (v == 0) begin
							open_ext_header();
						end else begin
							enter_phase(PH_EXT_BODY);
							hs_count = 17'(v);
						end
					end
				end
			end
			PH_EXT_BODY: begin
				hs_count = hs_count - 1'b1;
				if (hs_count == 0)
					open_ext_header();
			end
			PH_SNI_HDR: begin
				// list length, name type, then name length
				hs_count = hs_count + 1'b1;
				if (hs_count == 3) begin
					hs_ext_type = {8'h00, b};
				end else if (hs_count >= 4) begin
					hs_acc = {hs_acc[7:0], b};
					v = hs_acc;
					if (hs_count == 5) begin
						rest = int'(hs_ext_end) - int'(hs_pos);
						if (hs_ext_type == 16'(NAME_TYPE_HOST) && v <= rest) begin
							hs_matched = 1;
							hs_name_len = 16'(v);
							if (v == 0) begin
								hs_complete = 1;
								enter_phase(PH_DONE);
							end else begin
								enter_phase(PH_NAME);
								hs_name_left = 16'(v);
							end
						end else if (rest == 0) begin
							open_ext_header();
						end else begin
							enter_phase(PH_EXT_BODY);
							hs_count = 17'(rest);
						end
					end
				end
			end
			PH_NAME: begin
				is_name = 1;
				hs_name_left = hs_name_left - 1'b1;
				if (hs_name_left == 0) begin
					hs_complete = 1;
					enter_phase(PH_DONE);
				end
			end
			default: enter_phase(PH_DONE);
		endcase
	endtask

	task automatic predict_sni_beats(input logic [7:0] b, input logic last);
		bit is_name;
		res_t r;
		is_name = 0;
		// hold the position at its ceiling and stop parsing there
		if (int'(hs_pos) < POS_MAX) begin
			hs_pos = hs_pos + 1'b1;
			parse_octet(b, is_name);
		end
		if (is_name) begin
			r.kind = KIND_NAME;
			r.name_char = b;
			r.found = 1'b0;
			r.name_length = '0;
			r.run_end = ~last;
			sni_beats_due.push_back(r);
		end
		if (last) begin
			r.kind = KIND_VERDICT;
			r.name_char = '0;
			r.found = hs_complete && hs_matched && hs_ext_end <= hs_pos;
			r.name_length = r.found ? hs_name_len : 16'd0;
			r.run_end = 1'b1;
			sni_beats_due.push_back(r);
			clear_parser();
		end
	endtask

	task automatic note_mismatch(input string what, input logic [31:0] got_v,
			input logic [31:0] want_v);
		$display("%0t: %s: got %h, expected %h", $realtime, what, got_v, want_v);
		mismatch_count++;
	endtask

	task automatic put16(ref octets_t p, input int v);
		p.push_back(8'(v >> 8));
		p.push_back(8'(v));
	endtask

	task automatic put_random(ref octets_t p, input int n);
		for (int i = 0; i < n; i++)
			p.push_back(8'($urandom));
	endtask

	task automatic queue_packet(ref octets_t p, input bit drain);
		stim_t s;
		foreach (p[i]) begin
			s.data = p[i];
			s.last = (i == p.size() - 1);
			s.drain = drain && i == 0;
			stim_q.push_back(s);
		end
	endtask

	task automatic hello_head(ref octets_t p, input int sid_n, input int cs_n, input int cm_n);
		p.push_back(REC_HANDSHAKE);
		put_random(p, REC_HDR_REST);
		p.push_back(HS_CLIENT_HELLO);
		put_random(p, HS_FIXED_LEN);
		p.push_back(8'(sid_n));
		put_random(p, sid_n);
		put16(p, cs_n);
		put_random(p, cs_n);
		p.push_back(8'(cm_n));
		put_random(p, cm_n);
	endtask

	// body opens with a name entry header; random filler after it
	task automatic add_ext(ref octets_t p, input int etype, input int elen, input int ntype,
			input int nlen);
		logic [7:0] hdr [5];
		hdr = '{8'($urandom), 8'($urandom), 8'(ntype), 8'(nlen >> 8), 8'(nlen)};
		put16(p, etype);
		put16(p, elen);
		for (int i = 0; i < elen; i++)
			p.push_back(i < 5 ? hdr[i] : 8'($urandom));
	endtask

	task automatic close_hello(ref octets_t p, ref octets_t x, input int len_delta,
			input int tail_n, input int keep_n, input bit drain);
		int dl;
		dl = x.size() + len_delta;
		put16(p, dl < 0 ? 0 : (dl > 65535 ? 65535 : dl));
		foreach (x[i])
			p.push_back(x[i]);
		put_random(p, tail_n);
		while (keep_n > 0 && p.size() > keep_n)
			void'(p.pop_back());
		queue_packet(p, drain);
	endtask

	task automatic random_packet(input bit drain);
		octets_t p;
		octets_t x;
		int n_ext;
		int sni_at;
		int nlen;
		int elen;
		int ntype;
		int etype;
		int delta;
		int keep;
		if ($urandom_range(0, 99) < 10) begin
			// noise
			put_random(p, $urandom_range(1, 40));
			if ($urandom_range(0, 1))
				p[0] = REC_HANDSHAKE;
			queue_packet(p, drain);
		end else begin
			hello_head(p, $urandom_range(0, 3) == 0 ? $urandom_range(0, 255) : $urandom_range(0, 32),
				$urandom_range(0, 20) * 2, $urandom_range(0, 3));
			n_ext = $urandom_range(0, 4);
			sni_at = $urandom_range(0, 5) == 0 ? -1 : $urandom_range(0, n_ext);
			for (int i = 0; i <= n_ext; i++) begin
				if (i == sni_at) begin
					nlen = $urandom_range(0, 24);
					elen = 5 + nlen + ($urandom_range(0, 3) == 0 ? $urandom_range(0, 4) : 0);
					if ($urandom_range(0, 9) == 0)
						elen = $urandom_range(0, 4 + nlen);
					if ($urandom_range(0, 19) == 0) begin
						elen = $urandom_range(5, 8);
						nlen = $urandom_range(0, 65535);
					end
					ntype = $urandom_range(0, 7) == 0 ? $urandom_range(1, 255) : NAME_TYPE_HOST;
					add_ext(x, EXT_SERVER_NAME, elen, ntype, nlen);
				end else if (i < n_ext) begin
					etype = $urandom_range(0, 3) == 0 ? EXT_SERVER_NAME : $urandom_range(1, 65535);
					elen = etype == EXT_SERVER_NAME ? $urandom_range(0, 4) : $urandom_range(0, 12);
					add_ext(x, etype, elen, $urandom_range(0, 255), $urandom_range(0, 65535));
				end
			end
			case ($urandom_range(0, 9))
				0: delta = -$urandom_range(1, 8);
				1: delta = $urandom_range(1, 8);
				default: delta = 0;
			endcase
			if ($urandom_range(0, 19) == 0)
				p[5] = 8'($urandom_range(2, 255));
			keep = $urandom_range(0, 99) < 15 ? $urandom_range(1, p.size() + 2 + x.size()) : 0;
			close_hello(p, x, delta, $urandom_range(0, 4), keep, drain);
		end
	endtask

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#(TIMEOUT_NS);
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

	// driver: present beats from stim_q, idle at random
	always @(negedge clk) begin
		bit quiet;
		bit go;
		stim_t s;
		quiet = cycle_count >= QUIET_FROM && cycle_count < QUIET_TO;
		if (arst_n && (!in_valid || in_taken)) begin
			in_taken = 1'b0;
			go = stim_q.size() != 0 && (quiet || $urandom_range(0, 99) >= 26);
			// hold a marked packet until every due beat is out
			if (go && stim_q[0].drain && sni_beats_due.size() != 0)
				go = 0;
			if (go) begin
				s = stim_q.pop_front();
				data_byte <= s.data;
				final_byte <= s.last;
			end else begin
				data_byte <= 8'($urandom);
				final_byte <= 1'($urandom_range(0, 1));
			end
			in_valid <= go;
		end
		out_ready <= arst_n && (quiet || $urandom_range(0, 99) >= 26);
	end

	// monitor: predict on accepted input beats, check accepted output beats
	always @(posedge clk) begin
		res_t got;
		res_t want;
		cycle_count++;
		if (arst_n && in_valid && in_ready) begin
			predict_sni_beats(data_byte, final_byte);
			in_taken = 1'b1;
		end
		if (arst_n && out_valid && out_ready) begin
			got.kind = kind;
			got.name_char = name_char;
			got.found = found;
			got.name_length = name_length;
			got.run_end = run_end;
			if (sni_beats_due.size() == 0) begin
				note_mismatch("beat with nothing due", 32'(got), 32'd0);
			end else begin
				want = sni_beats_due.pop_front();
				if (got.kind !== want.kind)
					note_mismatch("kind", 32'(got.kind), 32'(want.kind));
				if (got.name_char !== want.name_char)
					note_mismatch("name_char", 32'(got.name_char), 32'(want.name_char));
				if (got.found !== want.found)
					note_mismatch("found", 32'(got.found), 32'(want.found));
				if (got.name_length !== want.name_length)
					note_mismatch("name_length", 32'(got.name_length), 32'(want.name_length));
				if (got.run_end !== want.run_end)
					note_mismatch("run_end", 32'(got.run_end), 32'(want.run_end));
			end
		end
	end

	initial begin
		octets_t p;
		octets_t x;
		int random_bytes;
		int mark;
		int pkt_no;
		arst_n = 1'b0;
		in_valid = 1'b0;
		data_byte = '0;
		final_byte = 1'b0;
		out_ready = 1'b0;
		in_taken = 1'b0;
		cycle_count = 0;
		mismatch_count = 0;
		clear_parser();

		// lone bytes: record header alone, all ones, all zeros
		p.push_back(REC_HANDSHAKE);
		queue_packet(p, 0);
		p.delete();
		p.push_back(8'hFF);
		queue_packet(p, 0);
		p.delete();
		p.push_back(8'h00);
		queue_packet(p, 0);
		// wrong handshake type
		p.delete();
		p.push_back(REC_HANDSHAKE);
		put_random(p, REC_HDR_REST);
		p.push_back(8'h02);
		put_random(p, 3);
		queue_packet(p, 0);
		// empty name
		p.delete();
		x.delete();
		hello_head(p, 0, 0, 0);
		add_ext(x, EXT_SERVER_NAME, 5, NAME_TYPE_HOST, 0);
		close_hello(p, x, 0, 2, 0, 0);
		// empty extension first, packet ends on the last name byte
		p.delete();
		x.delete();
		hello_head(p, 1, 2, 1);
		add_ext(x, 16'h0017, 0, 0, 0);
		add_ext(x, EXT_SERVER_NAME, 8, NAME_TYPE_HOST, 3);
		close_hello(p, x, 0, 0, 0, 1);
		// unsuitable name type, then a good entry
		p.delete();
		x.delete();
		hello_head(p, 32, 4, 1);
		add_ext(x, EXT_SERVER_NAME, 9, 1, 4);
		add_ext(x, EXT_SERVER_NAME, 11, NAME_TYPE_HOST, 6);
		close_hello(p, x, 0, 1, 0, 0);
		// names longer than their extension
		p.delete();
		x.delete();
		hello_head(p, 0, 2, 1);
		add_ext(x, EXT_SERVER_NAME, 7, NAME_TYPE_HOST, 5);
		add_ext(x, EXT_SERVER_NAME, 6, NAME_TYPE_HOST, 16'hFFFF);
		add_ext(x, 16'hFFFF, 2, 0, 0);
		close_hello(p, x, 0, 3, 0, 0);
		// extension runs past the list end
		p.delete();
		x.delete();
		hello_head(p, 0, 2, 1);
		add_ext(x, 16'h0010, 10, 0, 0);
		add_ext(x, EXT_SERVER_NAME, 9, NAME_TYPE_HOST, 4);
		close_hello(p, x, -3, 0, 0, 0);
		// packet ends mid-name
		p.delete();
		x.delete();
		hello_head(p, 2, 6, 2);
		add_ext(x, EXT_SERVER_NAME, 25, NAME_TYPE_HOST, 20);
		close_hello(p, x, 0, 0, p.size() + 2 + 4 + 5 + 8, 0);
		// name complete, extension cut short
		p.delete();
		x.delete();
		hello_head(p, 0, 2, 1);
		add_ext(x, EXT_SERVER_NAME, 14, NAME_TYPE_HOST, 6);
		close_hello(p, x, 0, 0, p.size() + 2 + 4 + 5 + 6, 1);

		random_bytes = 0;
		pkt_no = 0;
		while (random_bytes < 950) begin
			mark = stim_q.size();
			random_packet(pkt_no % 6 == 5);
			random_bytes += stim_q.size() - mark;
			pkt_no++;
		end

		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		while (stim_q.size() != 0 || in_valid)
			@(posedge clk);
		while (sni_beats_due.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (mismatch_count == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
